>>> design/ccfr_pkg.sv
// Shared types, constants and CRC function for the checked frame receiver.
package ccfr_pkg;

    localparam int BUFFER_BYTES_DEF = 64;
    localparam int HDR_BYTES        = 4;
    localparam int M_TDATA_W        = 40;
    localparam int M_TUSER_W        = 3;
    localparam int CFG_INDEX_W      = 2;
    localparam int CFG_DATA_W       = 8;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [5:0]  MAX_LEN_RESET = 6'd60;
    localparam logic [7:0]  START_RESET   = 8'd83;

    typedef enum logic [2:0] {
        EV_HUNT     = 3'd0,
        EV_PROGRESS = 3'd1,
        EV_PAYLOAD  = 3'd2,
        EV_GOOD     = 3'd3,
        EV_CRC_ERR  = 3'd4,
        EV_LEN_ERR  = 3'd5
    } event_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAX_LEN = 2'd0,
        REG_START   = 2'd1
    } reg_index_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> design/crc_checked_frame_receiver.sv
// Top level of the CRC-16 checked byte-stream frame receiver.
//
// Usage:
//   s_ channel carries one received serial byte per item (s_tdata).
//   m_ channel returns exactly one result item per input item: the event
//   code on m_tuser and the payload byte, payload index, message id,
//   component id and payload length packed on m_tdata.
//   Frame: start byte, length, message id, component id, payload bytes,
//   CRC-16/CCITT-FALSE low byte then high byte over length..last payload.
//   Payload bytes stream out with their index; commit them on frame good.
//   cfg_ channel writes max_payload_len (index 0) and start_char (index 1)
//   while the block is idle; the user must keep to this, as the block does
//   not enforce it. cfg_ready is always high. Results are registered.
//   Throughput: one item per cycle unless the output stalls; the frame
//   state and CRC update with each accepted item, and the output register
//   takes a new item whenever it is empty or drained in the same cycle.
//   Stall: when m_tready is low with a result held, s_tready drops.
//   Reset (aresetn low, synchronous): hunting, CRC 0xFFFF, stored header
//   fields zero, registers back to 60 and 'S', output empty.
module crc_checked_frame_receiver
    import ccfr_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] rx_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] payload_byte, [13:8] payload_index, [21:14] msg_id,
    // [29:22] comp_id, [37:30] payload_length, [39:38] zero
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic [M_TUSER_W-1:0]   m_tuser,   // [2:0] event_res
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [8:0] BUF_LIMIT = 9'(BUFFER_BYTES);
    localparam logic [8:0] HDR_W     = 9'(HDR_BYTES);

    logic [5:0]  max_len_reg;
    logic [7:0]  start_char_reg;

    logic        in_frame_reg, in_frame_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [7:0]  frame_length_reg, frame_length_next;
    logic [7:0]  frame_message_reg, frame_message_next;
    logic [7:0]  frame_component_reg, frame_component_next;
    logic [15:0] running_crc_reg, running_crc_next;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    event_t               m_event_reg, ev_next;

    logic        s_accept;
    logic [7:0]  b;
    logic [7:0]  pbyte;
    logic [5:0]  pidx;
    logic        len_rej;
    logic [7:0]  len_out;
    logic [8:0]  crc_pos;
    logic [15:0] crc_in;
    logic [15:0] crc_upd;

    assign b         = s_tdata;
    assign s_tready  = ~m_valid_reg | m_tready;
    assign s_accept  = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_event_reg;

    assign crc_pos = (HDR_W - 9'd1) + {1'b0, frame_length_reg};
    assign crc_in  = (byte_count_reg == 8'd0) ? CRC_INIT : running_crc_reg;
    assign crc_upd = crc_byte(crc_in, b);

    always_comb begin
        in_frame_next        = in_frame_reg;
        byte_count_next      = byte_count_reg;
        frame_length_next    = frame_length_reg;
        frame_message_next   = frame_message_reg;
        frame_component_next = frame_component_reg;
        running_crc_next     = running_crc_reg;
        ev_next              = EV_HUNT;
        pbyte                = 8'd0;
        pidx                 = 6'd0;
        len_rej              = 1'b0;
        if (!in_frame_reg) begin
            if (b == start_char_reg) begin
                in_frame_next   = 1'b1;
                byte_count_next = 8'd0;
                ev_next         = EV_PROGRESS;
            end
        end else if (byte_count_reg == 8'd0) begin
            if (b > {2'b00, max_len_reg} || ({1'b0, b} + HDR_W) > BUF_LIMIT) begin
                ev_next         = EV_LEN_ERR;
                len_rej         = 1'b1;
                in_frame_next   = 1'b0;
                byte_count_next = 8'd0;
            end else begin
                frame_length_next = b;
                running_crc_next  = crc_upd;
                byte_count_next   = 8'd1;
                ev_next           = EV_PROGRESS;
            end
        end else if (byte_count_reg == 8'd1) begin
            frame_message_next = b;
            running_crc_next   = crc_upd;
            byte_count_next    = 8'd2;
            ev_next            = EV_PROGRESS;
        end else if (byte_count_reg == 8'd2) begin
            frame_component_next = b;
            running_crc_next     = crc_upd;
            byte_count_next      = 8'd3;
            ev_next              = EV_PROGRESS;
        end else if ({1'b0, byte_count_reg} < crc_pos) begin
            running_crc_next = crc_upd;
            pbyte            = b;
            pidx             = 6'(byte_count_reg - 8'd3);
            byte_count_next  = byte_count_reg + 8'd1;
            ev_next          = EV_PAYLOAD;
        end else if ({1'b0, byte_count_reg} == crc_pos) begin
            if (b != running_crc_reg[7:0]) begin
                ev_next         = EV_CRC_ERR;
                in_frame_next   = 1'b0;
                byte_count_next = 8'd0;
            end else begin
                byte_count_next = byte_count_reg + 8'd1;
                ev_next         = EV_PROGRESS;
            end
        end else begin
            ev_next         = (b == running_crc_reg[15:8]) ? EV_GOOD : EV_CRC_ERR;
            in_frame_next   = 1'b0;
            byte_count_next = 8'd0;
        end
        len_out      = len_rej ? b : frame_length_next;
        m_tdata_next = {2'b00, len_out, frame_component_next, frame_message_next,
                        pidx, pbyte};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg    <= MAX_LEN_RESET;
            start_char_reg <= START_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_MAX_LEN: max_len_reg    <= cfg_data[5:0];
                REG_START:   start_char_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg        <= 1'b0;
            byte_count_reg      <= 8'd0;
            frame_length_reg    <= 8'd0;
            frame_message_reg   <= 8'd0;
            frame_component_reg <= 8'd0;
            running_crc_reg     <= CRC_INIT;
        end else if (s_accept) begin
            in_frame_reg        <= in_frame_next;
            byte_count_reg      <= byte_count_next;
            frame_length_reg    <= frame_length_next;
            frame_message_reg   <= frame_message_next;
            frame_component_reg <= frame_component_next;
            running_crc_reg     <= running_crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= m_tdata_next;
            m_event_reg <= ev_next;
        end
    end

endmodule

>>> test/tb.sv
// Self-checking testbench for the CRC-checked frame receiver: directed frames, then random traffic.
`timescale 1ns / 1ps

module tb;
    import ccfr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum int {
        CRC_INTACT,
        CRC_BAD_LOW,
        CRC_BAD_HIGH
    } crc_fault_t;

    typedef struct {
        event_t     ev;
        logic [7:0] pbyte;
        logic [5:0] pidx;
        logic [7:0] msg;
        logic [7:0] comp;
        logic [7:0] len;
    } frame_result_t;

    class frame_event_checker;
        logic [5:0]    max_len;
        logic [7:0]    start_char;
        bit            in_frame;
        logic [7:0]    byte_count;
        logic [7:0]    frame_len;
        logic [7:0]    frame_msg;
        logic [7:0]    frame_comp;
        logic [15:0]   crc;
        frame_result_t expected_events[$];
        int unsigned   failures;
        int unsigned   results_seen;
        int unsigned   event_count[6];

        function new();
            max_len      = MAX_LEN_RESET;
            start_char   = START_RESET;
            in_frame     = 1'b0;
            byte_count   = '0;
            frame_len    = '0;
            frame_msg    = '0;
            frame_comp   = '0;
            crc          = CRC_INIT;
            failures     = 0;
            results_seen = 0;
            foreach (event_count[k]) event_count[k] = 0;
        endfunction

        static function logic [15:0] crc_update(input logic [15:0] crc_in, input logic [7:0] b);
            logic [15:0] c;
            bit          fb;
            int          i;
            c = crc_in;
            for (i = 7; i >= 0; i--) begin
                fb = c[15] ^ b[i];
                c  = {c[14:0], 1'b0};
                if (fb) begin
                    c = c ^ CRC_POLY;
                end
            end
            return c;
        endfunction

        function void report_failure(input string what);
            failures++;
            if (failures <= 10) begin
                $display("mismatch: %s", what);
            end
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void set_register(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
            case (idx)
                REG_MAX_LEN: max_len = value[5:0];
                REG_START:   start_char = value;
                default:     ;
            endcase
        endfunction

        function void note_byte(input logic [7:0] b);
            frame_result_t r;
            bit            rejected;
            int            crc_lo_pos;
            rejected   = 1'b0;
            r.ev       = EV_HUNT;
            r.pbyte    = '0;
            r.pidx     = '0;
            crc_lo_pos = HDR_BYTES - 1 + int'(frame_len);
            if (!in_frame) begin
                if (b == start_char) begin
                    in_frame   = 1'b1;
                    byte_count = '0;
                    r.ev       = EV_PROGRESS;
                end
            end else if (byte_count == 8'd0) begin
                if (b > max_len || int'(b) + HDR_BYTES > BUFFER_BYTES_DEF) begin
                    r.ev       = EV_LEN_ERR;
                    rejected   = 1'b1;
                    in_frame   = 1'b0;
                    byte_count = '0;
                end else begin
                    frame_len  = b;
                    crc        = crc_update(CRC_INIT, b);
                    byte_count = 8'd1;
                    r.ev       = EV_PROGRESS;
                end
            end else if (byte_count == 8'd1) begin
                frame_msg  = b;
                crc        = crc_update(crc, b);
                byte_count = 8'd2;
                r.ev       = EV_PROGRESS;
            end else if (byte_count == 8'd2) begin
                frame_comp = b;
                crc        = crc_update(crc, b);
                byte_count = 8'd3;
                r.ev       = EV_PROGRESS;
            end else if (int'(byte_count) < crc_lo_pos) begin
                crc        = crc_update(crc, b);
                r.pbyte    = b;
                r.pidx     = 6'(byte_count - 8'd3);
                byte_count = byte_count + 8'd1;
                r.ev       = EV_PAYLOAD;
            end else if (int'(byte_count) == crc_lo_pos) begin
                if (b != crc[7:0]) begin
                    r.ev       = EV_CRC_ERR;
                    in_frame   = 1'b0;
                    byte_count = '0;
                end else begin
                    byte_count = byte_count + 8'd1;
                    r.ev       = EV_PROGRESS;
                end
            end else begin
                r.ev       = (b == crc[15:8]) ? EV_GOOD : EV_CRC_ERR;
                in_frame   = 1'b0;
                byte_count = '0;
            end
            r.msg  = frame_msg;
            r.comp = frame_comp;
            r.len  = rejected ? b : frame_len;
            expected_events.push_back(r);
        endfunction

        function void check_result(input logic [M_TUSER_W-1:0] ev,
                                   input logic [M_TDATA_W-1:0] data);
            frame_result_t e;
            logic [M_TDATA_W-1:0] want;
            results_seen++;
            if (expected_events.size() == 0) begin
                report_failure($sformatf("result %0d arrived with nothing expected (ev %0d data %h)",
                                         results_seen, ev, data));
                return;
            end
            e    = expected_events.pop_front();
            want = {2'b00, e.len, e.comp, e.msg, e.pidx, e.pbyte};
            event_count[e.ev]++;
            if (ev !== e.ev || data !== want) begin
                report_failure($sformatf(
                    {"result %0d: want ev %0d byte %h idx %0d msg %h comp %h len %0d;",
                     " got ev %0d byte %h idx %0d msg %h comp %h len %0d pad %b"},
                    results_seen, e.ev, e.pbyte, e.pidx, e.msg, e.comp, e.len,
                    ev, data[7:0], data[13:8], data[21:14], data[29:22], data[37:30],
                    data[39:38]));
            end
        endfunction

        function void close_out();
            if (expected_events.size() != 0) begin
                report_failure($sformatf("%0d results never arrived", expected_events.size()));
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    frame_event_checker sb;
    logic [7:0]         rx_stream[$];
    int                 send_idle_pct = 0;
    int                 rx_stall_pct = 0;
    int                 cycle_count = 0;

    crc_checked_frame_receiver i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tuser, m_tdata);
            end
            if (s_tvalid && s_tready) begin
                sb.note_byte(s_tdata);
            end
        end
    end

    function automatic logic [7:0] nonzero_byte();
        return 8'($urandom_range(255, 1));
    endfunction

    function automatic void add_frame(input logic [7:0] len, input logic [7:0] msg,
                                      input logic [7:0] comp, input logic [7:0] body[$],
                                      input crc_fault_t fault);
        logic [15:0] c;
        c = frame_event_checker::crc_update(CRC_INIT, len);
        c = frame_event_checker::crc_update(c, msg);
        c = frame_event_checker::crc_update(c, comp);
        rx_stream.push_back(sb.start_char);
        rx_stream.push_back(len);
        rx_stream.push_back(msg);
        rx_stream.push_back(comp);
        foreach (body[k]) begin
            rx_stream.push_back(body[k]);
            c = frame_event_checker::crc_update(c, body[k]);
        end
        if (fault == CRC_BAD_LOW) begin
            rx_stream.push_back(c[7:0] ^ nonzero_byte());
        end else begin
            rx_stream.push_back(c[7:0]);
            rx_stream.push_back((fault == CRC_BAD_HIGH) ? (c[15:8] ^ nonzero_byte()) : c[15:8]);
        end
    endfunction

    function automatic void fill_random(input int target);
        int          limit;
        int          short_limit;
        int          pick;
        int          len;
        int          extra;
        crc_fault_t  fault;
        logic [7:0]  body[$];
        limit       = (int'(sb.max_len) < BUFFER_BYTES_DEF - HDR_BYTES) ?
                      int'(sb.max_len) : BUFFER_BYTES_DEF - HDR_BYTES;
        short_limit = (limit < 8) ? limit : 8;
        while (rx_stream.size() < target) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                rx_stream.push_back(8'($urandom));
            end else if (pick < 18) begin
                rx_stream.push_back(sb.start_char);
                if ($urandom_range(1) == 0) begin
                    rx_stream.push_back(8'($urandom_range(limit + 4, limit + 1)));
                end else begin
                    rx_stream.push_back(8'($urandom_range(255, limit + 1)));
                end
            end else if (pick < 25) begin
                rx_stream.push_back(sb.start_char);
                rx_stream.push_back(8'($urandom_range(limit)));
                extra = $urandom_range(2);
                repeat (extra) rx_stream.push_back(8'($urandom));
            end else begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    len = $urandom_range(short_limit);
                end else if (pick < 95) begin
                    len = $urandom_range(limit);
                end else begin
                    len = limit;
                end
                body.delete();
                repeat (len) body.push_back(8'($urandom));
                pick = $urandom_range(99);
                fault = (pick < 80) ? CRC_INTACT : (pick < 90) ? CRC_BAD_LOW : CRC_BAD_HIGH;
                add_frame(8'(len), 8'($urandom), 8'($urandom), body, fault);
            end
        end
    endfunction

    task automatic drive_stream();
        int idx;
        bit bus_free;
        idx      = 0;
        bus_free = 1'b1;
        while (idx < rx_stream.size()) begin
            if (bus_free && $urandom_range(99) < send_idle_pct) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= rx_stream[idx];
            end
            @(posedge aclk);
            bus_free = !s_tvalid || s_tready;
            if (s_tvalid && s_tready) begin
                idx++;
            end
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_register(idx, value);
    endtask

    task automatic run_phase(input int send_pct, input int stall_pct, input int n,
                             input logic [7:0] max_value, input logic [7:0] start_value,
                             input bit spare_writes);
        write_reg(REG_MAX_LEN, max_value);
        write_reg(REG_START, start_value);
        if (spare_writes) begin
            write_reg(REG_SPARE_2, 8'($urandom));
            write_reg(REG_SPARE_3, 8'($urandom));
        end
        cfg_valid     <= 1'b0;
        send_idle_pct = send_pct;
        rx_stall_pct  = stall_pct;
        rx_stream.delete();
        fill_random(n);
        drive_stream();
        wait_idle();
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles without draining", cycle_count);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        logic [7:0] body[$];
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        rx_stream.delete();
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'hFF);
        body.delete();
        add_frame(8'd0, 8'hFF, 8'h00, body, CRC_INTACT);
        rx_stream.push_back(sb.start_char);
        rx_stream.push_back(8'd61);
        rx_stream.push_back(sb.start_char);
        rx_stream.push_back(8'hFF);
        body.push_back(8'h00);
        body.push_back(8'hFF);
        add_frame(8'd2, 8'h00, 8'hFF, body, CRC_BAD_HIGH);
        body.delete();
        add_frame(8'd0, 8'h01, 8'h02, body, CRC_BAD_LOW);
        drive_stream();
        wait_idle();

        run_phase(69, 0, 100, 8'hFF, 8'hFF, 1'b0);
        run_phase(0, 69, 100, 8'h40, 8'h00, 1'b0);
        run_phase(22, 22, 100, 8'd12, 8'h7E, 1'b1);
        run_phase(0, 0, 100, {2'b00, MAX_LEN_RESET}, START_RESET, 1'b1);
        run_phase(22, 22, 100, 8'($urandom), 8'($urandom), 1'b1);

        sb.close_out();
        $display("Checked %0d results over six register settings and four idle mixes",
                 sb.results_seen);
        $display("Frames: %0d good, %0d CRC errors, %0d length errors, %0d payload bytes",
                 sb.event_count[EV_GOOD], sb.event_count[EV_CRC_ERR],
                 sb.event_count[EV_LEN_ERR], sb.event_count[EV_PAYLOAD]);
        if (sb.failures == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
